/* rtl/ccpg_pkg.sv */
// shared types and constants for the character cell pixel generator
`default_nettype none
package ccpg_pkg;

  localparam int NumPix  = 8;
  localparam int AddrW   = 5;
  localparam int DataW   = 32;
  localparam int ColorW  = 4;
  localparam int ModeW   = 3;

  typedef logic [ColorW-1:0] color_t;

  typedef enum logic [ModeW-1:0] {
    MODE_STD_TEXT = 3'd0,
    MODE_MC_TEXT  = 3'd1,
    MODE_STD_BMP  = 3'd2,
    MODE_MC_BMP   = 3'd3,
    MODE_ECM_TEXT = 3'd4
  } mode_e;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_BORDER = 3'd1,
    REG_BACK0  = 3'd2,
    REG_BACK1  = 3'd3,
    REG_BACK2  = 3'd4,
    REG_BACK3  = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [ModeW-1:0] graphics_mode;
    color_t           border_color;
    color_t           back_color_0;
    color_t           back_color_1;
    color_t           back_color_2;
    color_t           back_color_3;
  } cfg_t;

  typedef struct packed {
    logic [7:0] char_byte;
    color_t     color_nibble;
    logic [7:0] data_byte;
    logic       visible;
    logic       in_border;
  } cell_t;

endpackage
`default_nettype wire

/* rtl/ccpg_if.sv */
// valid/ready channel interfaces for cell words and pixel words
`default_nettype none
interface ccpg_cell_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic [3:0] color_nibble;
  logic [7:0] data_byte;
  logic       visible;
  logic       in_border;

  modport source (output valid, char_byte, color_nibble, data_byte, visible, in_border,
                  input ready);
  modport sink (input valid, char_byte, color_nibble, data_byte, visible, in_border,
                output ready);
endinterface

interface ccpg_pix_if;
  logic       valid;
  logic       ready;
  logic [3:0] pixel_0;
  logic [3:0] pixel_1;
  logic [3:0] pixel_2;
  logic [3:0] pixel_3;
  logic [3:0] pixel_4;
  logic [3:0] pixel_5;
  logic [3:0] pixel_6;
  logic [3:0] pixel_7;

  modport source (output valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
                  pixel_6, pixel_7, input ready);
  modport sink (input valid, pixel_0, pixel_1, pixel_2, pixel_3, pixel_4, pixel_5,
                pixel_6, pixel_7, output ready);
endinterface
`default_nettype wire

/* rtl/ccpg_regs.sv */
// apb register file holding mode and color registers
`default_nettype none
module ccpg_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ccpg_pkg::AddrW-1:0] paddr,
  input  wire logic [ccpg_pkg::DataW-1:0] pwdata,
  output      logic [ccpg_pkg::DataW-1:0] prdata,
  output      logic                       pready,
  output      ccpg_pkg::cfg_t             cfg_o
);

  ccpg_pkg::cfg_t     cfg_q, cfg_d;
  ccpg_pkg::reg_idx_e idx;
  logic               wr_en;

  assign idx    = ccpg_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        ccpg_pkg::REG_MODE:   cfg_d.graphics_mode = pwdata[ccpg_pkg::ModeW-1:0];
        ccpg_pkg::REG_BORDER: cfg_d.border_color  = pwdata[ccpg_pkg::ColorW-1:0];
        ccpg_pkg::REG_BACK0:  cfg_d.back_color_0  = pwdata[ccpg_pkg::ColorW-1:0];
        ccpg_pkg::REG_BACK1:  cfg_d.back_color_1  = pwdata[ccpg_pkg::ColorW-1:0];
        ccpg_pkg::REG_BACK2:  cfg_d.back_color_2  = pwdata[ccpg_pkg::ColorW-1:0];
        ccpg_pkg::REG_BACK3:  cfg_d.back_color_3  = pwdata[ccpg_pkg::ColorW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ccpg_pkg::REG_MODE:   prdata = ccpg_pkg::DataW'(cfg_q.graphics_mode);
      ccpg_pkg::REG_BORDER: prdata = ccpg_pkg::DataW'(cfg_q.border_color);
      ccpg_pkg::REG_BACK0:  prdata = ccpg_pkg::DataW'(cfg_q.back_color_0);
      ccpg_pkg::REG_BACK1:  prdata = ccpg_pkg::DataW'(cfg_q.back_color_1);
      ccpg_pkg::REG_BACK2:  prdata = ccpg_pkg::DataW'(cfg_q.back_color_2);
      ccpg_pkg::REG_BACK3:  prdata = ccpg_pkg::DataW'(cfg_q.back_color_3);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule
`default_nettype wire

/* rtl/character_cell_pixel_generator.sv */
// character cell pixel generator: cell word in, eight 4-bit pixels out
// pipeline: a cell is held in the input register, then its pixels in the result register
// throughput: one cell per cycle while the pixel receiver stays ready; the single pass of pixel logic sets the figure
// cells on blanked lines, or in modes 5 to 7 outside the border, give no pixel word
// reset: asynchronous active low, empties both stages and clears the mode and color registers
// to zero; the cell and pixel data registers are not reset
`default_nettype none
module character_cell_pixel_generator (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  ccpg_cell_if.sink                       cell_i,
  ccpg_pix_if.source                      pix_o,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ccpg_pkg::AddrW-1:0] paddr,
  input  wire logic [ccpg_pkg::DataW-1:0] pwdata,
  output      logic [ccpg_pkg::DataW-1:0] prdata,
  output      logic                       pready
);

  ccpg_pkg::cfg_t  cfg;
  ccpg_pkg::cell_t cell_q, cell_in;
  logic            s1_valid_q, s1_valid_d;
  logic            out_valid_q, out_valid_d;
  logic            has_result, out_free, out_load, s1_adv, in_acc;
  ccpg_pkg::color_t pix_q [ccpg_pkg::NumPix];
  ccpg_pkg::color_t pix_d [ccpg_pkg::NumPix];
  ccpg_pkg::color_t lo, hi, ecm_bg, pair_col [ccpg_pkg::NumPix];
  logic [ccpg_pkg::NumPix-1:0] bit_c, bit_d;
  logic [1:0]      pair_c [ccpg_pkg::NumPix];
  logic [1:0]      pair_d [ccpg_pkg::NumPix];

  ccpg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign cell_in = '{char_byte:    cell_i.char_byte,
                     color_nibble: cell_i.color_nibble,
                     data_byte:    cell_i.data_byte,
                     visible:      cell_i.visible,
                     in_border:    cell_i.in_border};

  // word drops out when blanked, or when the mode is not a defined one and the cell is not in the border
  assign has_result = cell_q.visible &&
                      (cell_q.in_border ||
                       cfg.graphics_mode <= ccpg_pkg::ModeW'(ccpg_pkg::MODE_ECM_TEXT));
  assign out_free   = !out_valid_q || pix_o.ready;
  assign out_load   = s1_valid_q && has_result && out_free;
  assign s1_adv     = !s1_valid_q || !has_result || out_free;
  assign cell_i.ready = s1_adv;
  assign in_acc     = cell_i.valid && s1_adv;

  assign s1_valid_d  = s1_adv ? cell_i.valid : s1_valid_q;
  assign out_valid_d = out_load ? 1'b1 : (out_valid_q && !pix_o.ready);

  assign lo = cell_q.char_byte[3:0];
  assign hi = cell_q.char_byte[7:4];

  always_comb begin
    case (cell_q.data_byte[1:0])
      2'd0:    ecm_bg = cfg.back_color_0;
      2'd1:    ecm_bg = cfg.back_color_1;
      2'd2:    ecm_bg = cfg.back_color_2;
      default: ecm_bg = cfg.back_color_3;
    endcase
  end

  always_comb begin
    for (int k = 0; k < ccpg_pkg::NumPix; k++) begin
      bit_c[k]  = cell_q.char_byte[ccpg_pkg::NumPix-1-k];
      bit_d[k]  = cell_q.data_byte[ccpg_pkg::NumPix-1-k];
      // each bit pair covers two adjacent pixels
      pair_c[k] = cell_q.char_byte[2*(3-(k>>1)) +: 2];
      pair_d[k] = cell_q.data_byte[2*(3-(k>>1)) +: 2];
      if (cfg.graphics_mode == ccpg_pkg::ModeW'(ccpg_pkg::MODE_MC_BMP)) begin
        case (pair_d[k])
          2'd0:    pair_col[k] = cfg.back_color_0;
          2'd1:    pair_col[k] = lo;
          2'd2:    pair_col[k] = hi;
          default: pair_col[k] = cell_q.color_nibble;
        endcase
      end else begin
        case (pair_c[k])
          2'd0:    pair_col[k] = cfg.back_color_0;
          2'd1:    pair_col[k] = cfg.back_color_1;
          2'd2:    pair_col[k] = cfg.back_color_2;
          default: pair_col[k] = {1'b0, cell_q.color_nibble[2:0]};
        endcase
      end
    end
  end

  always_comb begin
    for (int k = 0; k < ccpg_pkg::NumPix; k++) begin
      if (cell_q.in_border) begin
        pix_d[k] = cfg.border_color;
      end else begin
        case (cfg.graphics_mode)
          ccpg_pkg::MODE_MC_TEXT: begin
            if (cell_q.color_nibble[3]) pix_d[k] = pair_col[k];
            else pix_d[k] = bit_c[k] ? cell_q.color_nibble : cfg.back_color_0;
          end
          ccpg_pkg::MODE_STD_BMP:  pix_d[k] = bit_d[k] ? hi : lo;
          ccpg_pkg::MODE_MC_BMP:   pix_d[k] = pair_col[k];
          ccpg_pkg::MODE_ECM_TEXT: pix_d[k] = bit_c[k] ? cell_q.color_nibble : ecm_bg;
          default:                 pix_d[k] = bit_c[k] ? cell_q.color_nibble
                                                       : cfg.back_color_0;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cell_q <= cell_in;
    end
    if (out_load) begin
      pix_q <= pix_d;
    end
  end

  assign pix_o.valid   = out_valid_q;
  assign pix_o.pixel_0 = pix_q[0];
  assign pix_o.pixel_1 = pix_q[1];
  assign pix_o.pixel_2 = pix_q[2];
  assign pix_o.pixel_3 = pix_q[3];
  assign pix_o.pixel_4 = pix_q[4];
  assign pix_o.pixel_5 = pix_q[5];
  assign pix_o.pixel_6 = pix_q[6];
  assign pix_o.pixel_7 = pix_q[7];

endmodule
`default_nettype wire

/* rtl/ccpg_checker.sv */
// port-level checks for the character cell pixel generator
`default_nettype none
module ccpg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_pixels,
  input wire logic        pready
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a new word must come from an accepted cell, through the input register and then the result register
  a_rise_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_acc, 2))
    else $error("pixel word appeared without a cell accepted two cycles earlier");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_pixels))
    else $error("stalled pixel word changed");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid)
    else $error("pixel word valid right after reset");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("register port not ready");

endmodule

bind character_cell_pixel_generator ccpg_checker u_ccpg_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (cell_i.valid),
  .in_ready   (cell_i.ready),
  .out_valid  (pix_o.valid),
  .out_ready  (pix_o.ready),
  .out_pixels ({pix_o.pixel_0, pix_o.pixel_1, pix_o.pixel_2, pix_o.pixel_3,
                pix_o.pixel_4, pix_o.pixel_5, pix_o.pixel_6, pix_o.pixel_7}),
  .pready     (pready)
);
`default_nettype wire

/* tb/tb_character_cell_pixel_generator.sv */
// self-checking testbench for the character cell pixel generator
`timescale 1ns / 1ps
module tb_character_cell_pixel_generator;

  typedef logic [ccpg_pkg::NumPix-1:0][ccpg_pkg::ColorW-1:0] pix_row_t;

  localparam int StallLimit   = 3000;
  localparam int SettleCycles = 4;
  localparam int PhaseItems   = 240;
  localparam int CfgSpan      = 40;
  // register indexes past the last mapped register
  localparam int unsigned RegUnmappedA = 6;
  localparam int unsigned RegUnmappedB = 7;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ccpg_pkg::AddrW-1:0] paddr;
  logic [ccpg_pkg::DataW-1:0] pwdata;
  logic [ccpg_pkg::DataW-1:0] prdata;
  logic pready;

  ccpg_cell_if cell_bus ();
  ccpg_pix_if  pix_bus ();

  character_cell_pixel_generator dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cell_i  (cell_bus),
    .pix_o   (pix_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  ccpg_pkg::cfg_t palette_regs;
  pix_row_t       pixel_words_pending[$];
  int             mismatch_count = 0;
  int             send_idle_pct = 0;
  int             recv_stall_pct = 0;
  int             stall_cycles = 0;

  // ---------------------------------------------------------------- predictor
  function automatic ccpg_pkg::color_t pick_color(input logic [1:0] sel,
                                                  input ccpg_pkg::color_t c0,
                                                  input ccpg_pkg::color_t c1,
                                                  input ccpg_pkg::color_t c2,
                                                  input ccpg_pkg::color_t c3);
    case (sel)
      2'd0: return c0;
      2'd1: return c1;
      2'd2: return c2;
      default: return c3;
    endcase
  endfunction

  function automatic pix_row_t hires_row(input logic [7:0] pattern,
                                         input ccpg_pkg::color_t on,
                                         input ccpg_pkg::color_t off);
    pix_row_t px;
    for (int i = 0; i < ccpg_pkg::NumPix; i++) px[i] = pattern[7-i] ? on : off;
    return px;
  endfunction

  // bit pairs, each pair drawn as two pixels
  function automatic pix_row_t multi_row(input logic [7:0] pattern,
                                         input ccpg_pkg::color_t c0,
                                         input ccpg_pkg::color_t c1,
                                         input ccpg_pkg::color_t c2,
                                         input ccpg_pkg::color_t c3);
    pix_row_t px;
    for (int i = 0; i < ccpg_pkg::NumPix; i++)
      px[i] = pick_color(pattern[7-2*(i/2) -: 2], c0, c1, c2, c3);
    return px;
  endfunction

  function automatic bit render_cell(input ccpg_pkg::cell_t c, input ccpg_pkg::cfg_t r,
                                     output pix_row_t px);
    ccpg_pkg::color_t lo;
    ccpg_pkg::color_t hi;
    lo = c.char_byte[3:0];
    hi = c.char_byte[7:4];
    px = '0;
    if (!c.visible) return 1'b0;
    if (c.in_border) begin
      for (int i = 0; i < ccpg_pkg::NumPix; i++) px[i] = r.border_color;
      return 1'b1;
    end
    case (r.graphics_mode)
      ccpg_pkg::MODE_STD_TEXT: px = hires_row(c.char_byte, c.color_nibble, r.back_color_0);
      ccpg_pkg::MODE_MC_TEXT: begin
        if (c.color_nibble[3]) begin
          px = multi_row(c.char_byte, r.back_color_0, r.back_color_1, r.back_color_2,
                         {1'b0, c.color_nibble[2:0]});
        end else begin
          px = hires_row(c.char_byte, c.color_nibble, r.back_color_0);
        end
      end
      ccpg_pkg::MODE_STD_BMP: px = hires_row(c.data_byte, hi, lo);
      ccpg_pkg::MODE_MC_BMP:  px = multi_row(c.data_byte, r.back_color_0, lo, hi,
                                             c.color_nibble);
      ccpg_pkg::MODE_ECM_TEXT: begin
        px = hires_row(c.char_byte, c.color_nibble,
                       pick_color(c.data_byte[1:0], r.back_color_0, r.back_color_1,
                                  r.back_color_2, r.back_color_3));
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  // ------------------------------------------------- predict, check, watchdog
  always @(posedge clk_i) begin : check_words
    pix_row_t seen;
    pix_row_t want;
    pix_row_t cell_px;
    if (rst_ni) begin
      if (pix_bus.valid && pix_bus.ready) begin
        seen = {pix_bus.pixel_7, pix_bus.pixel_6, pix_bus.pixel_5, pix_bus.pixel_4,
                pix_bus.pixel_3, pix_bus.pixel_2, pix_bus.pixel_1, pix_bus.pixel_0};
        if (pixel_words_pending.size() == 0) begin
          $display("%0t: pixel word with no cell pending: expected none, got %h",
                   $time, seen);
          mismatch_count++;
        end else begin
          want = pixel_words_pending.pop_front();
          for (int i = 0; i < ccpg_pkg::NumPix; i++) begin
            if (seen[i] !== want[i]) begin
              $display("%0t: pixel_%0d expected %h got %h", $time, i, want[i], seen[i]);
              mismatch_count++;
            end
          end
        end
      end
      if (cell_bus.valid && cell_bus.ready) begin
        if (render_cell({cell_bus.char_byte, cell_bus.color_nibble, cell_bus.data_byte,
                         cell_bus.visible, cell_bus.in_border}, palette_regs, cell_px))
          pixel_words_pending.push_back(cell_px);
      end
      if ((cell_bus.valid && cell_bus.ready) || (pix_bus.valid && pix_bus.ready) ||
          (psel && penable && pready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // receiver back-pressure
  initial begin
    pix_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      pix_bus.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_cell(input ccpg_pkg::cell_t c);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cell_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    cell_bus.valid        <= 1'b1;
    cell_bus.char_byte    <= c.char_byte;
    cell_bus.color_nibble <= c.color_nibble;
    cell_bus.data_byte    <= c.data_byte;
    cell_bus.visible      <= c.visible;
    cell_bus.in_border    <= c.in_border;
    do @(posedge clk_i); while (!cell_bus.ready);
  endtask

  // stop sending, wait for every pixel word, then let the pipeline settle
  task automatic pause_until_drained();
    @(negedge clk_i);
    cell_bus.valid <= 1'b0;
    while (pixel_words_pending.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input int unsigned idx, input logic [ccpg_pkg::DataW-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ccpg_pkg::AddrW'(idx * 4);
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      ccpg_pkg::REG_MODE:   palette_regs.graphics_mode = val[ccpg_pkg::ModeW-1:0];
      ccpg_pkg::REG_BORDER: palette_regs.border_color  = val[ccpg_pkg::ColorW-1:0];
      ccpg_pkg::REG_BACK0:  palette_regs.back_color_0  = val[ccpg_pkg::ColorW-1:0];
      ccpg_pkg::REG_BACK1:  palette_regs.back_color_1  = val[ccpg_pkg::ColorW-1:0];
      ccpg_pkg::REG_BACK2:  palette_regs.back_color_2  = val[ccpg_pkg::ColorW-1:0];
      ccpg_pkg::REG_BACK3:  palette_regs.back_color_3  = val[ccpg_pkg::ColorW-1:0];
      default: ;  // unmapped address, write dropped
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_palette(input int unsigned mode, input ccpg_pkg::color_t border,
                               input ccpg_pkg::color_t b0, input ccpg_pkg::color_t b1,
                               input ccpg_pkg::color_t b2, input ccpg_pkg::color_t b3);
    write_reg(ccpg_pkg::REG_MODE, ccpg_pkg::DataW'(mode));
    write_reg(ccpg_pkg::REG_BORDER, ccpg_pkg::DataW'(border));
    write_reg(ccpg_pkg::REG_BACK0, ccpg_pkg::DataW'(b0));
    write_reg(ccpg_pkg::REG_BACK1, ccpg_pkg::DataW'(b1));
    write_reg(ccpg_pkg::REG_BACK2, ccpg_pkg::DataW'(b2));
    write_reg(ccpg_pkg::REG_BACK3, ccpg_pkg::DataW'(b3));
  endtask

  task automatic load_random_palette();
    int unsigned pick;
    int unsigned mode;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      write_palette(ccpg_pkg::MODE_STD_TEXT, 4'h0, 4'h0, 4'h0, 4'h0, 4'h0);
    end else if (pick == 1) begin
      write_palette($urandom_range(0, 7), 4'hF, 4'hF, 4'hF, 4'hF, 4'hF);
    end else begin
      // invalid modes now and then
      mode = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
      write_palette(mode, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                    4'($urandom_range(0, 15)));
    end
  endtask

  function automatic ccpg_pkg::cell_t random_cell();
    ccpg_pkg::cell_t c;
    c.char_byte    = 8'($urandom_range(0, 255));
    c.color_nibble = 4'($urandom_range(0, 15));
    c.data_byte    = 8'($urandom_range(0, 255));
    c.visible      = ($urandom_range(0, 99) < 88);
    c.in_border    = ($urandom_range(0, 99) < 20);
    return c;
  endfunction

  // ------------------------------------------------------------------ tests
  // registers at reset values: standard text on a black background with a black border
  task automatic test_reset_palette();
    send_cell({8'hFF, 4'hF, 8'h00, 1'b1, 1'b0});
    send_cell({8'h5A, 4'h9, 8'hFF, 1'b1, 1'b0});
    send_cell({8'h00, 4'h3, 8'h00, 1'b1, 1'b1});
    pause_until_drained();
  endtask

  // every mode, valid and invalid, with border and blanked cells
  task automatic test_each_mode();
    write_reg(RegUnmappedA, 32'hFFFF_FFFF);
    write_reg(RegUnmappedB, 32'h0000_0005);
    for (int m = 0; m < 8; m++) begin
      write_palette(m, 4'(4'hF ^ m), 4'(m), 4'(m + 4), 4'(m + 8), 4'(m + 12));
      send_cell({8'hE4, 4'hF, 8'h1B, 1'b1, 1'b0});
      // clear multicolor flag; ECM select with upper bits set
      send_cell({8'h1B, 4'h7, 8'hC2, 1'b1, 1'b0});
      if (m % 2 == 0)
        send_cell({8'h00, 4'h0, 8'h00, 1'b1, 1'b1});
      else
        send_cell({8'hFF, 4'hF, 8'hFF, 1'b0, 1'b1});
      pause_until_drained();
    end
  endtask

  task automatic test_random_cells(input int src_pct, input int snk_pct);
    int              sent;
    int              since_cfg;
    ccpg_pkg::cell_t c;
    send_idle_pct  = src_pct;
    recv_stall_pct = snk_pct;
    sent      = 0;
    since_cfg = CfgSpan;
    while (sent < PhaseItems) begin
      if (since_cfg >= CfgSpan) begin
        pause_until_drained();
        load_random_palette();
        since_cfg = 0;
      end
      c = random_cell();
      send_cell(c);
      sent++;
      since_cfg++;
    end
    pause_until_drained();
  endtask

  initial begin
    rst_ni                = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    cell_bus.valid        = 1'b0;
    cell_bus.char_byte    = '0;
    cell_bus.color_nibble = '0;
    cell_bus.data_byte    = '0;
    cell_bus.visible      = 1'b0;
    cell_bus.in_border    = 1'b0;
    palette_regs          = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_palette();
    test_each_mode();
    test_random_cells(6, 83);
    test_random_cells(83, 6);
    test_random_cells(0, 0);

    pause_until_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

/* filelist.f */
rtl/ccpg_pkg.sv
rtl/ccpg_if.sv
rtl/ccpg_regs.sv
rtl/character_cell_pixel_generator.sv
rtl/ccpg_checker.sv
tb/tb_character_cell_pixel_generator.sv
